// ----- sv/strc_pkg.sv -----
// Package for the strided run coalescer: fixed field widths and result queue sizing.
// No dependencies; compiled first.
package strc_pkg;

    // Byte length of a scatter-gather block
    localparam int LEN_WIDTH   = 31;

    // One entry yields at most this many runs
    localparam int RESULTS_MAX = 2;

    // Result queue sizing
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
    localparam int FILL_WIDTH  = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- sv/strc_if.sv -----
// Channel interfaces of the strided run coalescer: entry words in, run words out.
// Depends on strc_pkg.
interface strc_entry_if #(
    parameter int ADDR_WIDTH = 48
);
    logic                           valid;
    logic                           ready;
    logic [ADDR_WIDTH-1:0]          entry_address;
    logic [strc_pkg::LEN_WIDTH-1:0] entry_length;
    logic                           last_entry;

    modport source (output valid, entry_address, entry_length, last_entry, input ready);
    modport sink   (input valid, entry_address, entry_length, last_entry, output ready);
endinterface

interface strc_run_if #(
    parameter int ADDR_WIDTH  = 48,
    parameter int COUNT_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic [ADDR_WIDTH-1:0]          request_base;
    logic signed [ADDR_WIDTH:0]     run_offset;
    logic [strc_pkg::LEN_WIDTH-1:0] run_block_size;
    logic [COUNT_WIDTH-1:0]         run_count;
    logic signed [ADDR_WIDTH:0]     run_stride;
    logic                           is_vector;
    logic                           last_run;

    modport source (output valid, request_base, run_offset, run_block_size, run_count,
                     run_stride, is_vector, last_run, input ready);
    modport sink   (input valid, request_base, run_offset, run_block_size, run_count,
                     run_stride, is_vector, last_run, output ready);
endinterface

// ----- sv/strided_run_coalescer_top.sv -----
// Strided run coalescer, top level: run detection and a small result queue.
// Depends on strc_pkg and the channel interfaces in strc_if.sv.
//
// Usage:
//   i_entry takes one scatter-gather word (address, length, last flag) per
//   cycle on valid && ready. o_run gives closed runs: base of the list,
//   signed offset of the run, block size, count, signed stride, vector flag
//   and last-run flag.
//   An entry is classified against the open run in the cycle it is taken:
//   one subtract against the previous block address and a compare. Runs it
//   closes (zero, one or two) are written into a four-word result queue at
//   the same edge, so a run appears on o_run from that queue register,
//   behind any words already queued.
//   Throughput: one entry per cycle while the queue holds two or fewer
//   words; the queue drains one word per cycle while o_run.ready is high. Only
//   an entry that breaks a run and is last of its list yields two words, and
//   the first entry of a list closes nothing, so words never outnumber entries
//   and with o_run.ready held high entries are taken every cycle.
//   Stall: if o_run.ready stays low, the queue fills and i_entry.ready drops
//   once fewer than two slots are free; no word is lost.
//   Reset (synchronous, active low): queue empty, no run open, and the next
//   entry starts a new list.
module strided_run_coalescer_top #(
    parameter int ADDR_WIDTH  = 48,
    parameter int COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    strc_entry_if.sink      i_entry,
    strc_run_if.source      o_run
);

    localparam int LW = strc_pkg::LEN_WIDTH;
    localparam int DW = ADDR_WIDTH + 1;                 // signed address difference
    localparam int CMPW = (DW > LW) ? DW : LW;          // stride vs length compare
    localparam int PW = strc_pkg::PTR_WIDTH;
    localparam int FW = strc_pkg::FILL_WIDTH;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]  request_base;
        logic [DW-1:0]          run_offset;
        logic [LW-1:0]          run_block_size;
        logic [COUNT_WIDTH-1:0] run_count;
        logic [DW-1:0]          run_stride;
        logic                   is_vector;
        logic                   last_run;
    } t_run;

    // Run state
    logic [ADDR_WIDTH-1:0]  r_list_base;
    logic                   r_first_pending;
    logic                   r_run_open;
    logic [ADDR_WIDTH-1:0]  r_run_start;
    logic [LW-1:0]          r_run_length;
    logic [COUNT_WIDTH-1:0] r_blocks;
    logic [DW-1:0]          r_stride;
    logic [ADDR_WIDTH-1:0]  r_prev_addr;

    // Result queue
    t_run                   r_fifo [strc_pkg::FIFO_DEPTH];
    logic [PW-1:0]          r_wr_ptr;
    logic [PW-1:0]          r_rd_ptr;
    logic [FW-1:0]          r_fill;

    logic                   in_fire;
    logic                   out_fire;
    logic [ADDR_WIDTH-1:0]  base_eff;
    logic                   open_eff;
    logic [DW-1:0]          addr_delta;
    logic                   stride_ok;
    logic                   run_grows;
    logic [COUNT_WIDTH-1:0] blocks_inc;
    logic                   saturated;
    logic                   emit_old;
    logic                   emit_new;
    t_run                   old_run;
    t_run                   new_run;
    t_run                   slot0;
    logic [FW-1:0]          push_n;

    assign in_fire  = i_entry.valid && i_entry.ready;
    assign out_fire = o_run.valid && o_run.ready;

    // First entry of a list sets the base and finds no run open
    assign base_eff = r_first_pending ? i_entry.entry_address : r_list_base;
    assign open_eff = r_run_open && !r_first_pending;

    assign addr_delta = {1'b0, i_entry.entry_address} - {1'b0, r_prev_addr};

    // Second block: forward distance of at least one block length
    assign stride_ok = !addr_delta[DW-1] &&
                       (CMPW'(addr_delta) >= CMPW'(r_run_length));

    always_comb begin
        run_grows = 1'b0;
        if (open_eff && (i_entry.entry_length == r_run_length)) begin
            if (r_blocks == COUNT_WIDTH'(1)) begin
                run_grows = stride_ok;
            end else begin
                run_grows = (addr_delta == r_stride);
            end
        end
    end

    assign blocks_inc = r_blocks + COUNT_WIDTH'(1);
    assign saturated  = (blocks_inc == {COUNT_WIDTH{1'b1}});

    // Old run closed by a breaking entry; then either the extended run or the
    // entry's own single-block run
    assign emit_old = open_eff && !run_grows;
    assign emit_new = run_grows ? (saturated || i_entry.last_entry) : i_entry.last_entry;

    always_comb begin
        old_run.request_base   = base_eff;
        old_run.run_offset     = {1'b0, r_run_start} - {1'b0, base_eff};
        old_run.run_block_size = r_run_length;
        old_run.run_count      = r_blocks;
        old_run.is_vector      = (r_blocks >= COUNT_WIDTH'(2));
        old_run.run_stride     = old_run.is_vector ? r_stride : '0;
        old_run.last_run       = 1'b0;

        new_run.request_base = base_eff;
        new_run.last_run     = i_entry.last_entry;
        if (run_grows) begin
            new_run.run_offset     = {1'b0, r_run_start} - {1'b0, base_eff};
            new_run.run_block_size = r_run_length;
            new_run.run_count      = blocks_inc;
            new_run.run_stride     = (r_blocks == COUNT_WIDTH'(1)) ? addr_delta : r_stride;
            new_run.is_vector      = 1'b1;
        end else begin
            new_run.run_offset     = {1'b0, i_entry.entry_address} - {1'b0, base_eff};
            new_run.run_block_size = i_entry.entry_length;
            new_run.run_count      = COUNT_WIDTH'(1);
            new_run.run_stride     = '0;
            new_run.is_vector      = 1'b0;
        end
    end

    assign slot0  = emit_old ? old_run : new_run;
    assign push_n = in_fire ? (FW'(emit_old) + FW'(emit_new)) : '0;

    // Room for the worst case of two words
    assign i_entry.ready = (r_fill <= FW'(strc_pkg::FIFO_DEPTH - strc_pkg::RESULTS_MAX));

    // Run state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_base     <= '0;
            r_first_pending <= 1'b1;
            r_run_open      <= 1'b0;
            r_run_start     <= '0;
            r_run_length    <= '0;
            r_blocks        <= '0;
            r_stride        <= '0;
            r_prev_addr     <= '0;
        end else if (in_fire) begin
            r_list_base     <= base_eff;
            r_first_pending <= 1'b0;
            if (run_grows) begin
                if (r_blocks == COUNT_WIDTH'(1)) begin
                    r_stride <= addr_delta;
                end
                r_blocks    <= blocks_inc;
                r_prev_addr <= i_entry.entry_address;
                r_run_open  <= !saturated;
            end else begin
                r_run_open   <= 1'b1;
                r_run_start  <= i_entry.entry_address;
                r_run_length <= i_entry.entry_length;
                r_blocks     <= COUNT_WIDTH'(1);
                r_stride     <= '0;
                r_prev_addr  <= i_entry.entry_address;
            end
            // End of list: clear everything, next entry opens a new list
            if (i_entry.last_entry) begin
                r_first_pending <= 1'b1;
                r_run_open      <= 1'b0;
                r_run_start     <= '0;
                r_run_length    <= '0;
                r_blocks        <= '0;
                r_stride        <= '0;
                r_prev_addr     <= '0;
            end
        end
    end

    // Queue storage, up to two writes a cycle
    always_ff @(posedge i_clk) begin
        if (push_n != '0) begin
            r_fifo[r_wr_ptr] <= slot0;
        end
        if (push_n == FW'(2)) begin
            r_fifo[r_wr_ptr + PW'(1)] <= new_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(push_n);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_fill <= r_fill + push_n - FW'(out_fire);
        end
    end

    assign o_run.valid          = (r_fill != '0);
    assign o_run.request_base   = r_fifo[r_rd_ptr].request_base;
    assign o_run.run_offset     = r_fifo[r_rd_ptr].run_offset;
    assign o_run.run_block_size = r_fifo[r_rd_ptr].run_block_size;
    assign o_run.run_count      = r_fifo[r_rd_ptr].run_count;
    assign o_run.run_stride     = r_fifo[r_rd_ptr].run_stride;
    assign o_run.is_vector      = r_fifo[r_rd_ptr].is_vector;
    assign o_run.last_run       = r_fifo[r_rd_ptr].last_run;

endmodule
